// File: design/gcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types and constants for the grid ray caster.
// ----------------------------------------------------------------------------
package gcr_pkg;

    localparam int MAP_SIDE_DEFAULT = 32;
    localparam int CELL_BITS        = 6;
    localparam int CELL_UNITS       = 64;
    localparam int CELL_MASK        = 63;
    localparam int WALL_LIMIT       = 127;
    localparam int CELL_W           = 8;

    // world coordinate while walking, input position, trig width
    localparam int COORD_W = 20;
    localparam int POS_W   = 16;
    localparam int TRIG_W  = 18;
    localparam int STEP_W  = 8;
    localparam int PROD_W  = STEP_W + TRIG_W;
    // dividend: travel (COORD_W+1 bits) shifted left by 16
    localparam int DVD_W   = COORD_W + 1 + 16;
    localparam int DIST_W  = 31;

    localparam logic [DIST_W-1:0] NO_HIT_DIST = 31'h7FFF_FFFF;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] FACE_EAST  = 2'd0;
    localparam logic [1:0] FACE_NORTH = 2'd1;
    localparam logic [1:0] FACE_WEST  = 2'd2;
    localparam logic [1:0] FACE_SOUTH = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_RD,
        ST_CHK,
        ST_DDIV
    } t_state;

endpackage

// File: design/gcr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module gcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/gcr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcr_div
// Signed divider, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcr_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [gcr_pkg::DVD_W-1:0]  i_dividend,
    input  logic signed [gcr_pkg::TRIG_W-1:0] i_divisor,
    output logic                              o_done,
    output logic signed [gcr_pkg::DVD_W-1:0]  o_quot
);
    import gcr_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic              r_run, r_done, r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_q;
    logic [TRIG_W-1:0] r_rem, r_dmag;
    logic [TRIG_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_q[DVD_W-1]};
    assign fits  = trial >= {1'b0, r_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CNT_W'(DVD_W - 1);
                r_q   <= i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : i_dividend;
                r_dmag <= i_divisor[TRIG_W-1] ? TRIG_W'(-i_divisor) : i_divisor;
                r_neg <= i_dividend[DVD_W-1] ^ i_divisor[TRIG_W-1];
                r_rem <= '0;
            end else if (r_run) begin
                r_rem <= fits ? TRIG_W'(trial - {1'b0, r_dmag}) : trial[TRIG_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);

    a_done_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_run))
        else $error("divider done without a run");
    a_start_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_run)
        else $error("divider did not start");
    a_no_done_while_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> !o_done)
        else $error("divider done while running");
endmodule

// File: design/grid_ray_caster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_caster
// Walks a ray through a square map of 64-unit cells to the first wall.
// ----------------------------------------------------------------------------
// Usage:
//   Command port: an item transfers on a rising edge with start high and busy
//   low. i_cmd = write stores i_cell_value into the map cell holding
//   (i_pos_x, i_pos_y); positions off the map are dropped. A write leaves
//   busy low. i_cmd = cast starts a ray at (i_pos_x,
//   i_pos_y) along (i_cos_value, i_sin_value), both scaled by 65536.
//   Result: one transfer per cast, o_valid high for exactly one cycle. The
//   receiver cannot stall; the result must be taken when shown.
//   Sequence: every cell crossing passes through a multiply state, a
//   compare state, a signed division on the shared divider, and the map
//   read and check states (ST_RD, ST_CHK). A hit adds one more division
//   for the distance. A cast with both sine and cosine zero answers a
//   miss in the next cycle. The divider (one quotient bit per cycle) sets
//   the pace.
//   Reset: synchronous, active low; clears the sequencer. Map contents are
//   undefined until written, and no clearing pass is done.
// ----------------------------------------------------------------------------
module grid_ray_caster #(
    parameter int MAP_SIDE_CELLS = gcr_pkg::MAP_SIDE_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic signed [gcr_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [gcr_pkg::POS_W-1:0]  i_pos_y,
    input  logic [gcr_pkg::CELL_W-1:0]        i_cell_value,
    input  logic signed [gcr_pkg::TRIG_W-1:0] i_sin_value,
    input  logic signed [gcr_pkg::TRIG_W-1:0] i_cos_value,
    output logic                              o_valid,
    output logic [gcr_pkg::CELL_W-1:0]        o_hit_cell,
    output logic [1:0]                        o_hit_face,
    output logic [gcr_pkg::CELL_BITS-1:0]     o_hit_offset,
    output logic [gcr_pkg::DIST_W-1:0]        o_hit_distance
);
    import gcr_pkg::*;

    localparam int DEPTH = MAP_SIDE_CELLS * MAP_SIDE_CELLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAP_SIDE_CELLS);
    localparam logic signed [COORD_W-1:0] LIM = COORD_W'(MAP_SIDE_CELLS * CELL_UNITS);

    t_state r_state, n_state;

    // ray registers
    logic signed [POS_W-1:0]   r_px, r_py;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic signed [TRIG_W-1:0]  r_s, r_c;
    logic signed [STEP_W-1:0]  r_dx, r_dy;
    logic signed [PROD_W-1:0]  r_pxs, r_pyc;
    logic                      r_xbr, r_inmap;

    // result registers
    logic                    r_valid;
    logic [CELL_W-1:0]       r_cell;
    logic [1:0]              r_face;
    logic [CELL_BITS-1:0]    r_off;
    logic [DIST_W-1:0]       r_dist;

    logic signed [STEP_W-1:0]  dx, dy;
    logic [PROD_W-1:0]         abs_xs, abs_yc;
    logic                      xbr_now, div_sel;
    logic signed [COORD_W:0]   travel;
    logic signed [DVD_W-1:0]   dvd;
    logic signed [TRIG_W-1:0]  dvs;
    logic                      div_start, div_done;
    logic signed [DVD_W-1:0]   quot;
    logic signed [COORD_W-1:0] q_step;

    logic signed [COORD_W-1:0] ax, ay;
    logic                      a_inmap;
    logic [AW-1:0]             addr;
    logic                      we;
    logic [CELL_W-1:0]         rdata, v;
    logic                      hit, brk;
    logic [DIST_W-1:0]         dist_sat;

    // ---- next cell edge and cross products ----
    assign dx = (r_c > 0 ? STEP_W'(CELL_UNITS) : -STEP_W'(1))
              - $signed({2'b00, r_x[CELL_BITS-1:0]});
    assign dy = (r_s > 0 ? STEP_W'(CELL_UNITS) : -STEP_W'(1))
              - $signed({2'b00, r_y[CELL_BITS-1:0]});
    assign abs_xs = r_pxs[PROD_W-1] ? PROD_W'(-r_pxs) : PROD_W'(r_pxs);
    assign abs_yc = r_pyc[PROD_W-1] ? PROD_W'(-r_pyc) : PROD_W'(r_pyc);
    assign xbr_now = abs_xs < abs_yc;

    // ---- shared divider operands: step in CMP, distance in CHK ----
    assign div_sel = (r_state == ST_CMP) ? xbr_now : r_xbr;
    assign travel  = r_xbr ? (COORD_W+1)'(r_x) - (COORD_W+1)'(r_px)
                           : (COORD_W+1)'(r_y) - (COORD_W+1)'(r_py);
    assign dvd = (r_state == ST_CMP)
               ? (div_sel ? DVD_W'(r_pxs) : DVD_W'(r_pyc))
               : {travel, 16'h0000};
    assign dvs = div_sel ? r_c : r_s;

    gcr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign q_step = quot[COORD_W-1:0];

    // ---- map address: input position when idle, ray position otherwise ----
    assign ax = busy ? r_x : COORD_W'(i_pos_x);
    assign ay = busy ? r_y : COORD_W'(i_pos_y);
    assign a_inmap = !ax[COORD_W-1] && !ay[COORD_W-1]
                  && (ax[COORD_W-1:CELL_BITS] < (COORD_W-CELL_BITS)'(MAP_SIDE_CELLS))
                  && (ay[COORD_W-1:CELL_BITS] < (COORD_W-CELL_BITS)'(MAP_SIDE_CELLS));
    assign addr = AW'(AW'(ay[CELL_BITS+IW-1:CELL_BITS]) * AW'(MAP_SIDE_CELLS))
                + AW'(ax[CELL_BITS+IW-1:CELL_BITS]);
    assign we = start && !busy && (i_cmd == CMD_WRITE) && a_inmap;

    gcr_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (addr),
        .i_wdata (i_cell_value),
        .o_rdata (rdata)
    );

    assign v   = r_inmap ? rdata : '0;
    assign hit = v > CELL_W'(WALL_LIMIT);
    // stop once off the map and still heading away from it
    assign brk = (v == '0)
              && ((r_s < 0 && r_y < 0) || (r_s > 0 && r_y >= LIM)
               || (r_c < 0 && r_x < 0) || (r_c > 0 && r_x >= LIM));

    assign dist_sat = quot[DVD_W-1] ? '0
                    : (quot > $signed({{(DVD_W-DIST_W){1'b0}}, NO_HIT_DIST}))
                    ? NO_HIT_DIST : quot[DIST_W-1:0];

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start && i_cmd == CMD_CAST && (i_sin_value != 0 || i_cos_value != 0))
                    n_state = ST_MUL;
            end
            ST_MUL:  n_state = ST_CMP;
            ST_CMP:  n_state = ST_DIV;
            ST_DIV:  if (div_done) n_state = ST_RD;
            ST_RD:   n_state = ST_CHK;
            ST_CHK: begin
                if (hit)      n_state = ST_DDIV;
                else if (brk) n_state = ST_IDLE;
                else          n_state = ST_MUL;
            end
            ST_DDIV: if (div_done) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- control outputs ----
    always_comb begin
        busy      = 1'b1;
        div_start = 1'b0;
        case (r_state)
            ST_IDLE: busy = 1'b0;
            ST_CMP:  div_start = 1'b1;
            ST_CHK:  div_start = hit;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            case (r_state)
                ST_IDLE: r_valid <= start && i_cmd == CMD_CAST
                                 && i_sin_value == 0 && i_cos_value == 0;
                ST_CHK:  r_valid <= !hit && brk;
                ST_DDIV: r_valid <= div_done;
                default: ;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_x  <= COORD_W'(i_pos_x);
                r_y  <= COORD_W'(i_pos_y);
                r_s  <= i_sin_value;
                r_c  <= i_cos_value;
                r_cell <= '0;
                r_face <= FACE_EAST;
                r_off  <= '0;
                r_dist <= NO_HIT_DIST;
            end
            ST_MUL: begin
                r_dx  <= dx;
                r_dy  <= dy;
                r_pxs <= PROD_W'(dx * r_s);
                r_pyc <= PROD_W'(dy * r_c);
            end
            ST_CMP: r_xbr <= xbr_now;
            ST_DIV: begin
                if (div_done) begin
                    if (r_xbr) begin
                        r_x <= r_x + COORD_W'(r_dx);
                        r_y <= r_y + q_step;
                    end else begin
                        r_x <= r_x + q_step;
                        r_y <= r_y + COORD_W'(r_dy);
                    end
                end
            end
            ST_RD: r_inmap <= a_inmap;
            ST_CHK: begin
                if (hit) begin
                    r_cell <= v;
                    if (r_xbr) begin
                        r_face <= (r_c > 0) ? FACE_WEST : FACE_EAST;
                        r_off  <= (r_c > 0) ? CELL_BITS'(CELL_MASK) - r_y[CELL_BITS-1:0]
                                            : r_y[CELL_BITS-1:0];
                    end else begin
                        r_face <= (r_s > 0) ? FACE_SOUTH : FACE_NORTH;
                        r_off  <= (r_s > 0) ? r_x[CELL_BITS-1:0]
                                            : CELL_BITS'(CELL_MASK) - r_x[CELL_BITS-1:0];
                    end
                end
            end
            ST_DDIV: if (div_done) r_dist <= dist_sat;
            default: ;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_hit_cell     = r_cell;
    assign o_hit_face     = r_face;
    assign o_hit_offset   = r_off;
    assign o_hit_distance = r_dist;

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");
    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_WRITE) |=> (!busy && !o_valid))
        else $error("map write started a cast");
    a_cast_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == CMD_CAST) |=> (busy || o_valid))
        else $error("cast dropped");
    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit_cell[CELL_W-1])
            |-> (o_hit_cell == '0 && o_hit_distance == NO_HIT_DIST))
        else $error("miss result malformed");
endmodule
